[rtl/bmh_pkg.sv]
// Shared types and constants for the binary max-heap core.
package bmh_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int CHILD_W  = CNT_W + 1;
    localparam int KEY_W    = 32;
    localparam int STAT_W   = 2;
    localparam int OUT_DATA_W = ((KEY_W + CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_TOP_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                    valid;
        cmd_t                    command;
        logic signed [KEY_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] top_value;
        logic [CNT_W-1:0]        entry_total;
        status_t                 status;
    } rsp_t;

endpackage

[rtl/binary_max_heap_core.sv]
// Top level of the binary max-heap priority queue: stream ports and result register.
//
// Binary max-heap of up to 64 signed 32-bit keys in a single on-chip RAM
// (one write port, two registered read ports). A command beat with tuser=0
// inserts tdata as a key; tuser=1 removes the root. Each command yields one
// result beat with the root after the command (zero when empty), the entry
// count, and a status (ok, insert refused when full, remove refused when
// empty). One command is in flight at a time. An insert climbs the key
// from the new last slot towards the root; a remove moves the last entry
// to the root and sinks it, unless it takes the last entry. Each level is
// one RAM read state (UP_RD or DN_RD) plus one compare/write state (UP_CMP
// or DN_CMP). Every command, refused ones too, ends by reading the root
// (TOP_RD) before the result is offered (DONE). The result sits in an
// output register, so a new command is taken while it waits for tready.
// The RAM needs no clearing after reset: only entries below the count are
// ever used.
module binary_max_heap_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] value
    input  logic [bmh_pkg::KEY_W-1:0]         s_axis_tdata,
    // [0] command
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] top_value, [38:32] entry_total, [39] zero
    output logic [bmh_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [bmh_pkg::STAT_W-1:0]        m_axis_tuser
);

    bmh_pkg::req_t req;
    bmh_pkg::rsp_t rsp;
    logic          rsp_ready;

    logic                                  out_valid_reg;
    logic signed [bmh_pkg::KEY_W-1:0]      top_reg;
    logic [bmh_pkg::CNT_W-1:0]             total_reg;
    bmh_pkg::status_t                      status_reg;

    assign req.valid   = s_axis_tvalid;
    assign req.command = bmh_pkg::cmd_t'(s_axis_tuser);
    assign req.value   = s_axis_tdata;

    bmh_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (s_axis_tready),
        .rsp       (rsp),
        .rsp_ready (rsp_ready)
    );

    // output register takes a result when empty or draining this cycle
    assign rsp_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= rsp.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_ready && rsp.valid)
        begin
            top_reg    <= rsp.top_value;
            total_reg  <= rsp.entry_total;
            status_reg <= rsp.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = bmh_pkg::OUT_DATA_W'({total_reg, top_reg});
    assign m_axis_tuser  = status_reg;

endmodule

[rtl/bmh_engine.sv]
// Heap storage and the sift-up / sift-down sequencer.
module bmh_engine
(
    input  logic          clk,
    input  logic          rst_n,
    input  bmh_pkg::req_t req,
    output logic          req_ready,
    output bmh_pkg::rsp_t rsp,
    input  logic          rsp_ready
);

    localparam logic [bmh_pkg::CNT_W-1:0] CNT_ONE = bmh_pkg::CNT_W'(1);

    logic signed [bmh_pkg::KEY_W-1:0] mem [bmh_pkg::CAPACITY];

    bmh_pkg::state_t state_reg, state_next;
    logic [bmh_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [bmh_pkg::ADDR_W-1:0] pos_reg, pos_next;
    logic signed [bmh_pkg::KEY_W-1:0] key_reg, key_next;
    bmh_pkg::status_t status_reg, status_next;

    logic                               we, re;
    logic [bmh_pkg::ADDR_W-1:0]         waddr, raddr_a, raddr_b;
    logic signed [bmh_pkg::KEY_W-1:0]   wdata, rda, rdb;

    // child and parent addresses of the current position
    logic [bmh_pkg::ADDR_W-1:0]  pos_m1, parent;
    logic [bmh_pkg::CHILD_W-1:0] left, right, fill;
    logic                        pick_right;

    assign pos_m1     = pos_reg - 1'b1;
    assign parent     = {1'b0, pos_m1[bmh_pkg::ADDR_W-1:1]};
    assign left       = {1'b0, pos_reg, 1'b1};
    assign right      = left + 1'b1;
    assign fill       = {1'b0, count_reg};
    assign pick_right = (right < fill) && (rda < rdb);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rda <= mem[raddr_a];
            rdb <= mem[raddr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bmh_pkg::ST_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            status_reg <= bmh_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = key_reg;
        re          = 1'b0;
        raddr_a     = pos_reg;
        raddr_b     = pos_reg;
        req_ready   = 1'b0;
        rsp.valid       = 1'b0;
        rsp.top_value   = (count_reg == '0) ? '0 : rda;
        rsp.entry_total = count_reg;
        rsp.status      = status_reg;

        case (state_reg)
            bmh_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    status_next = bmh_pkg::STAT_OK;
                    if (req.command == bmh_pkg::CMD_INSERT)
                    begin
                        if (count_reg == bmh_pkg::FULL_COUNT)
                        begin
                            status_next = bmh_pkg::STAT_FULL;
                            state_next  = bmh_pkg::ST_TOP_RD;
                        end
                        else
                        begin
                            pos_next   = count_reg[bmh_pkg::ADDR_W-1:0];
                            key_next   = req.value;
                            count_next = count_reg + 1'b1;
                            state_next = bmh_pkg::ST_UP_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = bmh_pkg::STAT_EMPTY;
                        state_next  = bmh_pkg::ST_TOP_RD;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = (count_reg == CNT_ONE) ? bmh_pkg::ST_TOP_RD
                                                            : bmh_pkg::ST_DN_LAST;
                    end
                end
            end
            bmh_pkg::ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = bmh_pkg::ST_TOP_RD;
                end
                else
                begin
                    re         = 1'b1;
                    raddr_a    = parent;
                    state_next = bmh_pkg::ST_UP_CMP;
                end
            end
            bmh_pkg::ST_UP_CMP:
            begin
                we = 1'b1;
                if (rda < key_reg)
                begin
                    wdata      = rda;
                    pos_next   = parent;
                    state_next = bmh_pkg::ST_UP_RD;
                end
                else
                begin
                    state_next = bmh_pkg::ST_TOP_RD;
                end
            end
            bmh_pkg::ST_DN_LAST:
            begin
                // count already dropped, so it addresses the old last entry
                re         = 1'b1;
                raddr_a    = count_reg[bmh_pkg::ADDR_W-1:0];
                state_next = bmh_pkg::ST_DN_LOAD;
            end
            bmh_pkg::ST_DN_LOAD:
            begin
                key_next   = rda;
                pos_next   = '0;
                state_next = bmh_pkg::ST_DN_RD;
            end
            bmh_pkg::ST_DN_RD:
            begin
                if (left >= fill)
                begin
                    we         = 1'b1;
                    state_next = bmh_pkg::ST_TOP_RD;
                end
                else
                begin
                    re         = 1'b1;
                    raddr_a    = left[bmh_pkg::ADDR_W-1:0];
                    raddr_b    = right[bmh_pkg::ADDR_W-1:0];
                    state_next = bmh_pkg::ST_DN_CMP;
                end
            end
            bmh_pkg::ST_DN_CMP:
            begin
                we = 1'b1;
                if (key_reg < (pick_right ? rdb : rda))
                begin
                    wdata      = pick_right ? rdb : rda;
                    pos_next   = pick_right ? right[bmh_pkg::ADDR_W-1:0]
                                            : left[bmh_pkg::ADDR_W-1:0];
                    state_next = bmh_pkg::ST_DN_RD;
                end
                else
                begin
                    state_next = bmh_pkg::ST_TOP_RD;
                end
            end
            bmh_pkg::ST_TOP_RD:
            begin
                re         = 1'b1;
                raddr_a    = '0;
                state_next = bmh_pkg::ST_DONE;
            end
            bmh_pkg::ST_DONE:
            begin
                rsp.valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = bmh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/bmh_checker.sv]
// Port-level assertions for the binary max-heap core, bound to the top level.
module bmh_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bmh_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [bmh_pkg::STAT_W-1:0]     m_axis_tuser
);

    logic [bmh_pkg::CNT_W-1:0] total;
    assign total = m_axis_tdata[bmh_pkg::KEY_W +: bmh_pkg::CNT_W];

    // one command at a time: the beat after an accept is never ready
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while another is in flight");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> total <= bmh_pkg::FULL_COUNT)
        else $error("entry count beyond capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == bmh_pkg::STAT_FULL
        |-> total == bmh_pkg::FULL_COUNT)
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == bmh_pkg::STAT_EMPTY
        |-> total == '0 && m_axis_tdata[bmh_pkg::KEY_W-1:0] == '0)
        else $error("empty status with entries or nonzero top");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat dropped or changed under backpressure");

endmodule

bind binary_max_heap_core bmh_checker u_bmh_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_top.sv]
// Self-checking testbench for binary_max_heap_core: command stream in, checked results out.
module tb_top;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 9;      // chance per cycle that a side idles
    localparam int RX_HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 40;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int MAX_REPORTS    = 10;

    localparam int KEY_W      = bmh_pkg::KEY_W;
    localparam int CNT_W      = bmh_pkg::CNT_W;
    localparam int STAT_W     = bmh_pkg::STAT_W;
    localparam int OUT_DATA_W = bmh_pkg::OUT_DATA_W;
    localparam int CAPACITY   = bmh_pkg::CAPACITY;

    // One result beat as the heap should report it.
    typedef struct {
        logic signed [KEY_W-1:0] top;
        logic [CNT_W-1:0]        total;
        bmh_pkg::status_t        status;
    } heap_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [KEY_W-1:0]        s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [STAT_W-1:0]       m_axis_tuser;

    // Shadow copy of the heap, updated as each command beat is accepted.
    logic signed [KEY_W-1:0] heap_keys [CAPACITY];
    int                      heap_count;

    heap_result_t            pending_results[$];

    // Stimulus controls shared with the receiver.
    bit                      no_idle;
    bit                      rx_hold_req;

    int                      cycle_count;
    int                      mismatch_count;
    int                      results_seen;
    int                      inserts_sent;
    int                      removes_sent;
    int                      full_refusals;
    int                      empty_refusals;
    int                      peak_count;

    binary_max_heap_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Apply one command to the shadow heap and return what the core must report.
    // Sift-up swaps only with a strictly smaller parent; sift-down takes the
    // larger child (left on a tie) and swaps only if it is strictly larger.
    function automatic heap_result_t heap_apply(bmh_pkg::cmd_t cmd,
                                                logic signed [KEY_W-1:0] key);
        heap_result_t            res;
        int                      pos;
        int                      parent;
        int                      left;
        int                      right;
        int                      pick;
        logic signed [KEY_W-1:0] tmp;
        bit                      done;
        res.status = bmh_pkg::STAT_OK;
        done = 1'b0;
        if (cmd == bmh_pkg::CMD_INSERT)
        begin
            if (heap_count >= CAPACITY)
                res.status = bmh_pkg::STAT_FULL;
            else
            begin
                heap_keys[heap_count] = key;
                pos = heap_count;
                heap_count++;
                while (pos > 0 && !done)
                begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[parent] < heap_keys[pos])
                    begin
                        tmp = heap_keys[parent];
                        heap_keys[parent] = heap_keys[pos];
                        heap_keys[pos] = tmp;
                        pos = parent;
                    end
                    else
                        done = 1'b1;
                end
            end
        end
        else
        begin
            if (heap_count == 0)
                res.status = bmh_pkg::STAT_EMPTY;
            else
            begin
                // last entry moves to the root, then sinks
                heap_keys[0] = heap_keys[heap_count - 1];
                heap_count--;
                pos = 0;
                while (!done && (2 * pos + 1) < heap_count)
                begin
                    left = 2 * pos + 1;
                    right = left + 1;
                    pick = left;
                    if (right < heap_count && heap_keys[left] < heap_keys[right])
                        pick = right;
                    if (heap_keys[pos] < heap_keys[pick])
                    begin
                        tmp = heap_keys[pos];
                        heap_keys[pos] = heap_keys[pick];
                        heap_keys[pick] = tmp;
                        pos = pick;
                    end
                    else
                        done = 1'b1;
                end
            end
        end
        res.top = (heap_count > 0) ? heap_keys[0] : '0;
        res.total = CNT_W'(heap_count);
        return res;
    endfunction

    // Key source: tie_pct of the keys come from a tiny range so equal keys
    // meet often; 8 percent are the signed extremes, zero or all ones; the rest are full 32-bit random.
    function automatic logic signed [KEY_W-1:0] pick_key(int tie_pct);
        int roll;
        int near;
        roll = $urandom_range(99);
        if (roll < tie_pct)
        begin
            near = int'($urandom_range(6)) - 3;
            return near;
        end
        else if (roll < tie_pct + 8)
        begin
            case ($urandom_range(3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one command beat. Called at a falling edge, returns at the falling
    // edge after the beat was taken. tvalid is left high for the next call.
    task automatic send_cmd(bmh_pkg::cmd_t cmd, logic signed [KEY_W-1:0] key);
        heap_result_t res;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = heap_apply(cmd, key);
        pending_results.push_back(res);
        if (cmd == bmh_pkg::CMD_INSERT)
            inserts_sent++;
        else
            removes_sent++;
        if (res.status == bmh_pkg::STAT_FULL)
            full_refusals++;
        if (res.status == bmh_pkg::STAT_EMPTY)
            empty_refusals++;
        if (heap_count > peak_count)
            peak_count = heap_count;
        @(negedge clk);
    endtask

    // Sender goes quiet until every result has been taken.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Empty heap, signed extremes, equal keys, refused remove on both ends.
    task automatic test_directed_edges();
        send_cmd(bmh_pkg::CMD_REMOVE, 32'sh1234_5678);
        send_cmd(bmh_pkg::CMD_INSERT, '0);
        send_cmd(bmh_pkg::CMD_INSERT, 32'sh8000_0000);
        send_cmd(bmh_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
        send_cmd(bmh_pkg::CMD_INSERT, '1);
        send_cmd(bmh_pkg::CMD_INSERT, 32'sd1);
        send_cmd(bmh_pkg::CMD_INSERT, 32'sd5);
        send_cmd(bmh_pkg::CMD_INSERT, 32'sd5);
        send_cmd(bmh_pkg::CMD_INSERT, 32'sd5);
        for (int i = 0; i < 8; i++)
            send_cmd(bmh_pkg::CMD_REMOVE, $urandom);
        send_cmd(bmh_pkg::CMD_REMOVE, '1);
        send_cmd(bmh_pkg::CMD_REMOVE, '0);
    endtask

    // Fill to capacity, push against the full heap, then drain past empty.
    task automatic test_fill_and_overflow(int tie_pct);
        while (heap_count < CAPACITY)
            send_cmd(bmh_pkg::CMD_INSERT, pick_key(tie_pct));
        for (int i = 0; i < 3; i++)
            send_cmd(bmh_pkg::CMD_INSERT, pick_key(tie_pct));
        while (heap_count > 0)
            send_cmd(bmh_pkg::CMD_REMOVE, $urandom);
        for (int i = 0; i < 2; i++)
            send_cmd(bmh_pkg::CMD_REMOVE, $urandom);
    endtask

    // Random commands; the insert share swings between phases so the heap
    // wanders between empty and full instead of sitting in the middle.
    task automatic test_random_mix(int n_items);
        int            insert_pct;
        bmh_pkg::cmd_t cmd;
        for (int k = 0; k < n_items; k++)
        begin
            insert_pct = ((k / 150) % 2 == 0) ? 72 : 30;
            cmd = ($urandom_range(99) < insert_pct) ? bmh_pkg::CMD_INSERT
                                                    : bmh_pkg::CMD_REMOVE;
            send_cmd(cmd, pick_key(25));
        end
    endtask

    // Receiver stops for a long stretch while commands keep coming, so the
    // output register fills and the input side has to stall.
    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_cmd(($urandom_range(99) < 60) ? bmh_pkg::CMD_INSERT : bmh_pkg::CMD_REMOVE,
                     pick_key(20));
    endtask

    // Back-to-back traffic on both sides.
    task automatic test_no_idle_stretch(int n_items);
        no_idle = 1'b1;
        test_random_mix(n_items);
        no_idle = 1'b0;
    endtask

    // Sender waits for the core to go quiet mid-stream, then resumes.
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_cmd(($urandom_range(99) < 65) ? bmh_pkg::CMD_INSERT : bmh_pkg::CMD_REMOVE,
                     pick_key(20));
        pause_until_drained();
        for (int i = 0; i < 20; i++)
            send_cmd(($urandom_range(99) < 40) ? bmh_pkg::CMD_INSERT : bmh_pkg::CMD_REMOVE,
                     pick_key(20));
    endtask

    // Receiver: random stalls, or a counted hold-off when a test asks for one.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else
                m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checker: every result beat against the oldest expectation.
    always @(posedge clk)
    begin
        heap_result_t exp_res;
        logic signed [KEY_W-1:0] got_top;
        logic [CNT_W-1:0] got_total;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got_top = m_axis_tdata[KEY_W-1:0];
            got_total = m_axis_tdata[KEY_W +: CNT_W];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0d] unexpected result beat: top=%0d total=%0d status=%0d",
                             cycle_count, got_top, got_total, m_axis_tuser);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got_top !== exp_res.top || got_total !== exp_res.total ||
                    m_axis_tuser !== exp_res.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"[%0d] result %0d: exp top=%0d total=%0d status=%0d,",
                                  " got top=%0d total=%0d status=%0d"},
                                 cycle_count, results_seen, exp_res.top, exp_res.total,
                                 exp_res.status, got_top, got_total, m_axis_tuser);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        no_idle        = 1'b0;
        rx_hold_req    = 1'b0;
        heap_count     = 0;
        mismatch_count = 0;
        results_seen   = 0;
        inserts_sent   = 0;
        removes_sent   = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        peak_count     = 0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_fill_and_overflow(60);
        test_random_mix(700);
        test_backpressure();
        test_no_idle_stretch(200);
        test_drain_pause();
        test_fill_and_overflow(5);
        test_random_mix(650);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Covered %0d inserts and %0d removes (%0d refused full, %0d refused empty),",
                 inserts_sent, removes_sent, full_refusals, empty_refusals);
        $display("peak depth %0d, %0d result beats checked, %0d mismatches.",
                 peak_count, results_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
